// File: sv/status_frame_parser_xor_check_macros.svh
// Assertion helpers for the frame parser checker
`ifndef STATUS_FRAME_PARSER_XOR_CHECK_MACROS_SVH
`define STATUS_FRAME_PARSER_XOR_CHECK_MACROS_SVH

// Same-cycle implication, held off during reset
`define SFPXC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset
`define SFPXC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/sfpxc_pkg.sv
package sfpxc_pkg;

  localparam int unsigned SFPXC_MAX_PAYLOAD = 8;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned MOTOR_W = 2;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  localparam logic [BYTE_W-1:0] RST_HEADER_FIRST    = 8'hAA;
  localparam logic [BYTE_W-1:0] RST_HEADER_SECOND   = 8'h55;
  localparam logic [BYTE_W-1:0] RST_FRAME_TYPE      = 8'h01;
  localparam logic [LEN_W-1:0]  RST_PAYLOAD_LENGTH  = 4'd5;
  localparam logic [BYTE_W-1:0] RST_PAUSE_MASK      = 8'h01;
  localparam logic [DUTY_W-1:0] RST_FAULT_THRESHOLD = 16'd800;

  typedef enum logic [2:0] {
    REG_HEADER_FIRST    = 3'd0,
    REG_HEADER_SECOND   = 3'd1,
    REG_FRAME_TYPE      = 3'd2,
    REG_PAYLOAD_LENGTH  = 3'd3,
    REG_PAUSE_MASK      = 3'd4,
    REG_FAULT_THRESHOLD = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_HEAD1   = 3'd0,
    PH_HEAD2   = 3'd1,
    PH_TYPE    = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_t;

  typedef enum logic [MOTOR_W-1:0] {
    MOTOR_STOPPED = 2'd0,
    MOTOR_NORMAL  = 2'd1,
    MOTOR_FAULT   = 2'd2
  } motor_t;

  typedef enum logic {
    FRAME_OK  = 1'b0,
    FRAME_BAD = 1'b1
  } frame_status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] header_first;
    logic [BYTE_W-1:0] header_second;
    logic [BYTE_W-1:0] frame_type;
    logic [LEN_W-1:0]  payload_length;
    logic [BYTE_W-1:0] pause_mask;
    logic [DUTY_W-1:0] fault_threshold;
  } sfpxc_cfg_t;

  typedef struct packed {
    frame_status_t     frame_status;
    logic [DUTY_W-1:0] duty_one;
    logic [DUTY_W-1:0] duty_two;
    logic              paused;
    motor_t            motor_state;
  } sfpxc_res_t;

endpackage

// File: sv/sfpxc_regs.sv
module sfpxc_regs
  import sfpxc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output sfpxc_cfg_t        cfg
);

  sfpxc_cfg_t cfg_r;
  sfpxc_cfg_t cfg_nxt;
  reg_idx_t   idx;
  logic       wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_HEADER_FIRST:    cfg_nxt.header_first    = pwdata[BYTE_W-1:0];
        REG_HEADER_SECOND:   cfg_nxt.header_second   = pwdata[BYTE_W-1:0];
        REG_FRAME_TYPE:      cfg_nxt.frame_type      = pwdata[BYTE_W-1:0];
        REG_PAYLOAD_LENGTH:  cfg_nxt.payload_length  = pwdata[LEN_W-1:0];
        REG_PAUSE_MASK:      cfg_nxt.pause_mask      = pwdata[BYTE_W-1:0];
        REG_FAULT_THRESHOLD: cfg_nxt.fault_threshold = pwdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_HEADER_FIRST:    prdata = DATA_W'(cfg_r.header_first);
      REG_HEADER_SECOND:   prdata = DATA_W'(cfg_r.header_second);
      REG_FRAME_TYPE:      prdata = DATA_W'(cfg_r.frame_type);
      REG_PAYLOAD_LENGTH:  prdata = DATA_W'(cfg_r.payload_length);
      REG_PAUSE_MASK:      prdata = DATA_W'(cfg_r.pause_mask);
      REG_FAULT_THRESHOLD: prdata = DATA_W'(cfg_r.fault_threshold);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first    <= RST_HEADER_FIRST;
      cfg_r.header_second   <= RST_HEADER_SECOND;
      cfg_r.frame_type      <= RST_FRAME_TYPE;
      cfg_r.payload_length  <= RST_PAYLOAD_LENGTH;
      cfg_r.pause_mask      <= RST_PAUSE_MASK;
      cfg_r.fault_threshold <= RST_FAULT_THRESHOLD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: sv/sfpxc_parse.sv
module sfpxc_parse
  import sfpxc_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = SFPXC_MAX_PAYLOAD
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              beat,
  input  logic [BYTE_W-1:0] rx_data,
  input  sfpxc_cfg_t        cfg,
  output logic              res_valid,
  output sfpxc_res_t        res
);

  localparam int unsigned SIDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [LEN_W:0]    MAX_CNT  = (LEN_W+1)'(MAX_PAYLOAD);
  localparam logic [BYTE_W-1:0] MAX_BYTE = BYTE_W'(MAX_PAYLOAD);

  phase_t            phase_r,  phase_nxt;
  logic [LEN_W-1:0]  index_r,  index_nxt;
  logic [LEN_W-1:0]  len_r,    len_nxt;
  logic [BYTE_W-1:0] xor_r,    xor_nxt;
  logic [DUTY_W-1:0] duty1_r,  duty1_nxt;
  logic [DUTY_W-1:0] duty2_r,  duty2_nxt;
  logic              pause_r,  pause_nxt;
  logic [BYTE_W-1:0] store_r [MAX_PAYLOAD];
  logic              store_we;
  logic              good;
  logic [LEN_W-1:0]  index_inc;

  assign index_inc = index_r + LEN_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    index_nxt = index_r;
    len_nxt   = len_r;
    xor_nxt   = xor_r;
    duty1_nxt = duty1_r;
    duty2_nxt = duty2_r;
    pause_nxt = pause_r;
    store_we  = 1'b0;
    res_valid = 1'b0;
    good      = (rx_data == xor_r);
    unique case (phase_r)
      PH_HEAD1: begin
        if (rx_data == cfg.header_first) begin
          phase_nxt = PH_HEAD2;
        end
      end
      PH_HEAD2: begin
        phase_nxt = (rx_data == cfg.header_second) ? PH_TYPE : PH_HEAD1;
      end
      PH_TYPE: begin
        xor_nxt   = rx_data;
        phase_nxt = (rx_data == cfg.frame_type) ? PH_LEN : PH_HEAD1;
      end
      PH_LEN: begin
        xor_nxt = xor_r ^ rx_data;
        if (rx_data == BYTE_W'(cfg.payload_length) && rx_data <= MAX_BYTE) begin
          len_nxt   = rx_data[LEN_W-1:0];
          index_nxt = '0;
          phase_nxt = (rx_data == '0) ? PH_CHECK : PH_PAYLOAD;
        end else begin
          phase_nxt = PH_HEAD1;
        end
      end
      PH_PAYLOAD: begin
        store_we  = ({1'b0, index_r} < MAX_CNT);
        index_nxt = index_inc;
        xor_nxt   = xor_r ^ rx_data;
        if (index_inc >= len_r) begin
          phase_nxt = PH_CHECK;
        end
      end
      PH_CHECK: begin
        phase_nxt = PH_HEAD1;
        res_valid = 1'b1;
        if (good) begin
          duty1_nxt = {store_r[0], store_r[1]};
          duty2_nxt = {store_r[2], store_r[3]};
          pause_nxt = |(store_r[4] & cfg.pause_mask);
        end
      end
      default: begin
        phase_nxt = PH_HEAD1;
      end
    endcase
  end

  always_comb begin
    res.frame_status = good ? FRAME_OK : FRAME_BAD;
    res.duty_one     = duty1_nxt;
    res.duty_two     = duty2_nxt;
    res.paused       = pause_nxt;
    if (duty2_nxt == '0 || pause_nxt) begin
      res.motor_state = MOTOR_STOPPED;
    end else if (duty2_nxt < cfg.fault_threshold) begin
      res.motor_state = MOTOR_NORMAL;
    end else begin
      res.motor_state = MOTOR_FAULT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD1;
      index_r <= '0;
      len_r   <= '0;
      xor_r   <= '0;
      duty1_r <= '0;
      duty2_r <= '0;
      pause_r <= 1'b0;
    end else if (beat) begin
      phase_r <= phase_nxt;
      index_r <= index_nxt;
      len_r   <= len_nxt;
      xor_r   <= xor_nxt;
      duty1_r <= duty1_nxt;
      duty2_r <= duty2_nxt;
      pause_r <= pause_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (beat && store_we) begin
      store_r[index_r[SIDX_W-1:0]] <= rx_data;
    end
  end

endmodule

// File: sv/status_frame_parser_xor_check.sv
// Status frame parser with XOR checksum.
// Input channel: one received byte per beat on in_rx_data (in_valid/in_ready).
// The parser hunts for header, header, type, length, payload and checksum.
// Every checksum byte yields one result beat on the out_ channel: frame
// status, the held duty values, the held pause flag and the motor state.
// A checksum byte accepted at a clock edge shows its result on the output
// register from the next cycle. One byte per cycle while in_ready is high;
// the byte update is a single pass of compare and XOR logic into the state.
// A new byte is taken while the held result is being taken; in_ready drops
// only while a result waits and out_ready is low, so a stalled receiver
// holds the parser without loss.
// Reset (rst_n, synchronous): hunt for the first header byte, checksum and
// held values cleared, registers back to their defaults, no result pending.
// Configuration through the APB port (register i at byte address 4*i) must be
// written only while the block is idle; the block itself does not enforce it.
module status_frame_parser_xor_check
  import sfpxc_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = SFPXC_MAX_PAYLOAD
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [BYTE_W-1:0]  in_rx_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_frame_status,
  output logic [DUTY_W-1:0]  out_duty_one,
  output logic [DUTY_W-1:0]  out_duty_two,
  output logic               out_paused,
  output logic [MOTOR_W-1:0] out_motor_state,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  sfpxc_cfg_t cfg;
  sfpxc_res_t res;
  sfpxc_res_t res_r;
  logic       res_valid;
  logic       beat;
  logic       out_valid_r, out_valid_nxt;

  sfpxc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfpxc_parse #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (beat),
    .rx_data   (in_rx_data),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign beat     = in_valid && in_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (beat && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (beat && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_status = res_r.frame_status;
  assign out_duty_one     = res_r.duty_one;
  assign out_duty_two     = res_r.duty_two;
  assign out_paused       = res_r.paused;
  assign out_motor_state  = res_r.motor_state;

endmodule

// File: sv/sfpxc_chk.sv
`include "status_frame_parser_xor_check_macros.svh"

module sfpxc_chk
  import sfpxc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_frame_status,
  input logic [DUTY_W-1:0]  out_duty_one,
  input logic [DUTY_W-1:0]  out_duty_two,
  input logic               out_paused,
  input logic [MOTOR_W-1:0] out_motor_state
);

  logic out_stall;

  assign out_stall = out_valid && !out_ready;

  `SFPXC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid, "result beat dropped while stalled")
  `SFPXC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_stall, $stable(out_frame_status) && $stable(out_duty_one) && $stable(out_duty_two) && $stable(out_paused) && $stable(out_motor_state), "result payload changed while stalled")
  `SFPXC_ASSERT_NOW(a_ready_only_stall, clk, rst_n, !in_ready, out_stall, "input held off without a stalled result")
  `SFPXC_ASSERT_NOW(a_paused_stops, clk, rst_n, out_valid && out_paused, out_motor_state == MOTOR_STOPPED, "paused frame not reported as stopped")
  `SFPXC_ASSERT_NOW(a_zero_duty_stops, clk, rst_n, out_valid && out_duty_two == '0, out_motor_state == MOTOR_STOPPED, "zero duty not reported as stopped")

endmodule

bind status_frame_parser_xor_check sfpxc_chk u_sfpxc_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_frame_status (out_frame_status),
  .out_duty_one     (out_duty_one),
  .out_duty_two     (out_duty_two),
  .out_paused       (out_paused),
  .out_motor_state  (out_motor_state)
);

// File: dv/status_frame_parser_xor_check_tb.sv
`timescale 1ns / 1ps

module status_frame_parser_xor_check_tb;
  import sfpxc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 240;
  localparam int unsigned SETTLE_CYCLES  = 4;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [BYTE_W-1:0]  in_rx_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_frame_status;
  logic [DUTY_W-1:0]  out_duty_one;
  logic [DUTY_W-1:0]  out_duty_two;
  logic               out_paused;
  logic [MOTOR_W-1:0] out_motor_state;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  status_frame_parser_xor_check i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_data       (in_rx_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_status (out_frame_status),
    .out_duty_one     (out_duty_one),
    .out_duty_two     (out_duty_two),
    .out_paused       (out_paused),
    .out_motor_state  (out_motor_state),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  sfpxc_cfg_t        cfg_shadow;
  phase_t            parse_phase;
  logic [LEN_W-1:0]  pay_idx;
  logic [LEN_W-1:0]  frame_len;
  logic [BYTE_W-1:0] xor_acc;
  logic [BYTE_W-1:0] pay_store [SFPXC_MAX_PAYLOAD];
  logic [DUTY_W-1:0] duty_one_held;
  logic [DUTY_W-1:0] duty_two_held;
  logic              pause_held;

  sfpxc_res_t        status_q [$];
  logic [BYTE_W-1:0] tx_bytes [$];

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  bit hold_request  = 1'b0;
  int quiet_cycles  = 0;
  int mismatches    = 0;
  int bytes_sent    = 0;
  int results_seen  = 0;
  int frames_ok     = 0;
  int frames_bad    = 0;
  int reg_writes    = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic track_byte(input logic [BYTE_W-1:0] b);
    sfpxc_res_t res;
    case (parse_phase)
      PH_HEAD1: begin
        if (b == cfg_shadow.header_first) parse_phase = PH_HEAD2;
      end
      PH_HEAD2: begin
        if (b == cfg_shadow.header_second) parse_phase = PH_TYPE;
        else parse_phase = PH_HEAD1;
      end
      PH_TYPE: begin
        xor_acc = b;
        if (b == cfg_shadow.frame_type) parse_phase = PH_LEN;
        else parse_phase = PH_HEAD1;
      end
      PH_LEN: begin
        xor_acc ^= b;
        if (b == BYTE_W'(cfg_shadow.payload_length) && b <= SFPXC_MAX_PAYLOAD) begin
          frame_len = b[LEN_W-1:0];
          pay_idx = '0;
          if (b == '0) parse_phase = PH_CHECK;
          else parse_phase = PH_PAYLOAD;
        end else begin
          parse_phase = PH_HEAD1;
        end
      end
      PH_PAYLOAD: begin
        if (pay_idx < SFPXC_MAX_PAYLOAD) pay_store[pay_idx] = b;
        pay_idx = pay_idx + 1'b1;
        xor_acc ^= b;
        if (pay_idx >= frame_len) parse_phase = PH_CHECK;
      end
      PH_CHECK: begin
        parse_phase = PH_HEAD1;
        if (b == xor_acc) begin
          res.frame_status = FRAME_OK;
          duty_one_held = {pay_store[0], pay_store[1]};
          duty_two_held = {pay_store[2], pay_store[3]};
          pause_held = |(pay_store[4] & cfg_shadow.pause_mask);
          frames_ok++;
        end else begin
          res.frame_status = FRAME_BAD;
          frames_bad++;
        end
        res.duty_one = duty_one_held;
        res.duty_two = duty_two_held;
        res.paused = pause_held;
        if (duty_two_held == '0 || pause_held) res.motor_state = MOTOR_STOPPED;
        else if (duty_two_held < cfg_shadow.fault_threshold) res.motor_state = MOTOR_NORMAL;
        else res.motor_state = MOTOR_FAULT;
        status_q.push_back(res);
      end
      default: parse_phase = PH_HEAD1;
    endcase
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_rx_data <= b;
    do @(posedge clk); while (!in_ready);
    track_byte(b);
    bytes_sent++;
  endtask

  task automatic send_queued();
    while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_HEADER_FIRST:    cfg_shadow.header_first    = value[BYTE_W-1:0];
      REG_HEADER_SECOND:   cfg_shadow.header_second   = value[BYTE_W-1:0];
      REG_FRAME_TYPE:      cfg_shadow.frame_type      = value[BYTE_W-1:0];
      REG_PAYLOAD_LENGTH:  cfg_shadow.payload_length  = value[LEN_W-1:0];
      REG_PAUSE_MASK:      cfg_shadow.pause_mask      = value[BYTE_W-1:0];
      REG_FAULT_THRESHOLD: cfg_shadow.fault_threshold = value[DUTY_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [31:0] h1, input logic [31:0] h2,
                              input logic [31:0] ftype, input logic [31:0] len,
                              input logic [31:0] mask, input logic [31:0] thr);
    settle();
    write_reg(REG_HEADER_FIRST, h1);
    write_reg(REG_HEADER_SECOND, h2);
    write_reg(REG_FRAME_TYPE, ftype);
    write_reg(REG_PAYLOAD_LENGTH, len);
    write_reg(REG_PAUSE_MASK, mask);
    write_reg(REG_FAULT_THRESHOLD, thr);
  endtask

  task automatic set_idling(input int src_pct, input int dst_pct);
    in_idle_pct = src_pct;
    out_stall_pct = dst_pct;
  endtask

  // payload bytes come from the top of fixed when use_fixed is set
  task automatic build_frame(input logic [BYTE_W-1:0] len_byte, input int n_payload,
                             input bit corrupt, input bit use_fixed,
                             input logic [63:0] fixed);
    logic [BYTE_W-1:0] chk;
    logic [BYTE_W-1:0] b;
    logic [DUTY_W-1:0] d2;
    tx_bytes.delete();
    tx_bytes.push_back(cfg_shadow.header_first);
    tx_bytes.push_back(cfg_shadow.header_second);
    tx_bytes.push_back(cfg_shadow.frame_type);
    tx_bytes.push_back(len_byte);
    chk = cfg_shadow.frame_type ^ len_byte;
    case ($urandom_range(7))
      0:       d2 = '0;
      1:       d2 = cfg_shadow.fault_threshold;
      2:       d2 = cfg_shadow.fault_threshold - 1'b1;
      3:       d2 = '1;
      default: d2 = DUTY_W'($urandom);
    endcase
    for (int i = 0; i < n_payload; i++) begin
      b = BYTE_W'($urandom);
      if (use_fixed) b = fixed[63-8*i -: 8];
      else if (i == 2) b = d2[15:8];
      else if (i == 3) b = d2[7:0];
      else if (i == 4 && $urandom_range(1) == 0) b = '0;
      chk ^= b;
      tx_bytes.push_back(b);
    end
    if (corrupt) chk ^= BYTE_W'($urandom_range(255, 1));
    tx_bytes.push_back(chk);
  endtask

  task automatic send_frame(input bit corrupt);
    build_frame(BYTE_W'(cfg_shadow.payload_length), int'(cfg_shadow.payload_length),
                corrupt, 1'b0, '0);
    send_queued();
  endtask

  task automatic send_fixed(input logic [63:0] fixed, input bit corrupt);
    build_frame(BYTE_W'(cfg_shadow.payload_length), int'(cfg_shadow.payload_length),
                corrupt, 1'b1, fixed);
    send_queued();
  endtask

  task automatic random_traffic(input int n_bytes);
    int start;
    int kind;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      kind = $urandom_range(99);
      build_frame(BYTE_W'(cfg_shadow.payload_length), int'(cfg_shadow.payload_length),
                  kind >= 70 && kind < 80, 1'b0, '0);
      if (kind >= 80 && kind < 85) begin
        tx_bytes[2] = tx_bytes[2] ^ BYTE_W'($urandom_range(255, 1));
      end else if (kind >= 85 && kind < 90) begin
        tx_bytes[3] = tx_bytes[3] ^ BYTE_W'($urandom_range(255, 1));
      end else if (kind >= 90 && kind < 95) begin
        tx_bytes[1] = tx_bytes[1] ^ BYTE_W'($urandom_range(255, 1));
      end else if (kind >= 95) begin
        tx_bytes.delete();
        repeat ($urandom_range(6, 1)) tx_bytes.push_back(BYTE_W'($urandom));
      end
      send_queued();
    end
  endtask

  task automatic test_directed_frames();
    set_idling(0, 0);
    send_fixed(64'hFFFF_FFFF_FF00_0000, 1'b0);
    send_fixed(64'h0000_0000_0000_0000, 1'b0);
    send_fixed(64'h1234_031F_FE00_0000, 1'b0);
    send_fixed(64'hABCD_0320_0000_0000, 1'b1);
    send_fixed(64'hABCD_0320_0000_0000, 1'b0);
  endtask

  task automatic test_header_resync();
    // a failed second header is not retried as a first header
    send_byte(cfg_shadow.header_first);
    send_fixed(64'h0102_0304_0500_0000, 1'b0);
    send_byte(cfg_shadow.header_first);
    send_byte(cfg_shadow.header_first);
    send_fixed(64'h0203_0405_0600_0000, 1'b0);
  endtask

  task automatic test_length_cases();
    settle();
    write_reg(REG_PAYLOAD_LENGTH, 32'd0);
    send_fixed('0, 1'b0);
    send_fixed('0, 1'b1);
    settle();
    write_reg(REG_PAYLOAD_LENGTH, 32'd3);
    send_fixed(64'h0456_0900_0000_0000, 1'b0);
    settle();
    write_reg(REG_PAYLOAD_LENGTH, 32'd12);
    build_frame(8'd12, 12, 1'b0, 1'b0, '0);
    send_queued();
    settle();
    write_reg(REG_PAYLOAD_LENGTH, 32'd15);
    build_frame(8'd15, 4, 1'b0, 1'b0, '0);
    send_queued();
    settle();
    write_reg(REG_PAYLOAD_LENGTH, 32'd8);
    send_frame(1'b0);
    build_frame(8'd5, 5, 1'b0, 1'b0, '0);
    send_queued();
    send_frame(1'b1);
    send_frame(1'b0);
  endtask

  task automatic test_mid_frame_config();
    build_frame(8'd8, 8, 1'b0, 1'b0, '0);
    repeat (6) send_byte(tx_bytes.pop_front());
    settle();
    write_reg(REG_PAYLOAD_LENGTH, 32'd5);
    write_reg(REG_PAUSE_MASK, 32'h80);
    send_queued();
    send_byte(cfg_shadow.header_first);
    settle();
    write_reg(REG_HEADER_SECOND, 32'h3C);
    write_reg(REG_FRAME_TYPE, 32'h7E);
    send_frame(1'b0);
    send_frame(1'b0);
  endtask

  task automatic test_config_sweep();
    set_idling(37, 37);
    apply_config(32'h00, 32'hFF, 32'hFF, 32'd8, 32'hFF, 32'h0000);
    random_traffic(100);
    apply_config(32'hFF, 32'h00, 32'h00, 32'd5, 32'h00, 32'hFFFF);
    random_traffic(100);
    apply_config($urandom_range(255), $urandom_range(255), $urandom_range(255), 32'd6,
                 $urandom_range(255), $urandom_range(65535));
    random_traffic(100);
    apply_config($urandom_range(255), $urandom_range(255), $urandom_range(255), 32'd7,
                 $urandom_range(255), $urandom_range(1200));
    random_traffic(100);
  endtask

  task automatic test_idle_phases();
    apply_config(32'(RST_HEADER_FIRST), 32'(RST_HEADER_SECOND), 32'(RST_FRAME_TYPE),
                 32'(RST_PAYLOAD_LENGTH), 32'(RST_PAUSE_MASK), 32'(RST_FAULT_THRESHOLD));
    set_idling(0, 0);
    random_traffic(160);
    set_idling(63, 0);
    random_traffic(160);
    set_idling(0, 63);
    random_traffic(160);
    set_idling(37, 37);
    random_traffic(160);
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    hold_request = 1'b1;
    repeat (6) send_frame(1'b0);
    send_frame(1'b1);
  endtask

  task automatic test_pause_for_results();
    set_idling(37, 37);
    random_traffic(40);
    settle();
    random_traffic(40);
  endtask

  initial begin
    cfg_shadow = '{header_first:    RST_HEADER_FIRST,
                   header_second:   RST_HEADER_SECOND,
                   frame_type:      RST_FRAME_TYPE,
                   payload_length:  RST_PAYLOAD_LENGTH,
                   pause_mask:      RST_PAUSE_MASK,
                   fault_threshold: RST_FAULT_THRESHOLD};
    parse_phase = PH_HEAD1;
    pay_idx = '0;
    frame_len = '0;
    xor_acc = '0;
    foreach (pay_store[i]) pay_store[i] = '0;
    duty_one_held = '0;
    duty_two_held = '0;
    pause_held = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frames();
    test_header_resync();
    test_length_cases();
    test_mid_frame_config();
    test_config_sweep();
    test_idle_phases();
    test_backpressure();
    test_pause_for_results();
    settle();
    repeat (8) @(posedge clk);
    $display("run covered %0d bytes: %0d good frames, %0d checksum errors, %0d results checked",
             bytes_sent, frames_ok, frames_bad, results_seen);
    $display("%0d register writes over header, type, length, mask and threshold; %0d mismatches",
             reg_writes, mismatches);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("status_frame_parser_xor_check verification clean");
    end else begin
      $display("status_frame_parser_xor_check verification failed");
    end
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    sfpxc_res_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (status_q.size() == 0) begin
        report_mismatch("result beat with nothing expected", 32'(out_frame_status), '0);
      end else begin
        want = status_q.pop_front();
        if (out_frame_status !== want.frame_status)
          report_mismatch("frame_status", 32'(out_frame_status), 32'(want.frame_status));
        if (out_duty_one !== want.duty_one)
          report_mismatch("duty_one", 32'(out_duty_one), 32'(want.duty_one));
        if (out_duty_two !== want.duty_two)
          report_mismatch("duty_two", 32'(out_duty_two), 32'(want.duty_two));
        if (out_paused !== want.paused)
          report_mismatch("paused", 32'(out_paused), 32'(want.paused));
        if (out_motor_state !== want.motor_state)
          report_mismatch("motor_state", 32'(out_motor_state), 32'(want.motor_state));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (!in_valid && status_q.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", quiet_cycles);
      $display("status_frame_parser_xor_check verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// File: filelist.f
+incdir+sv
sv/sfpxc_pkg.sv
sv/sfpxc_regs.sv
sv/sfpxc_parse.sv
sv/status_frame_parser_xor_check.sv
sv/sfpxc_chk.sv
dv/status_frame_parser_xor_check_tb.sv
